### hdl/record_delimiter_splitter_assert.svh
// Assertion macros shared by the record delimiter splitter modules.
`ifndef RECORD_DELIMITER_SPLITTER_ASSERT_SVH
`define RECORD_DELIMITER_SPLITTER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define RDS_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("record splitter assertion failed");

// A condition that holds in the same cycle as its trigger.
`define RDS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record splitter assertion failed");

// A condition that holds in the cycle after its trigger.
`define RDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record splitter assertion failed");

`endif

### hdl/rds_pkg.sv
// Shared types and constants of the record delimiter splitter.
`default_nettype none
package rds_pkg;

  localparam int DEFAULT_MAX_DELIMITER_BYTES = 8;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int LEN_W = 32;
  localparam int TERM_W = 4;
  localparam int POS_W = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PATTERN_W = 64;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam logic ACTION_FLUSH = 1'b1;
  localparam logic MODE_LINE = 1'b0;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_PATTERN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RECORD_BYTES = 2'd3;

  // Layout of a classified item in the queue.
  localparam int ITEM_ACTION_BIT = 0;
  localparam int ITEM_LF_BIT = 1;
  localparam int ITEM_CR_BIT = 2;
  localparam int ITEM_MATCH_LSB = 3;

  typedef struct packed {
    logic                 delimiter_mode;
    logic [TERM_W-1:0]    delimiter_count;
    logic [PATTERN_W-1:0] delimiter_pattern;
    logic [LEN_W-1:0]     max_record_bytes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    delimiter_mode:    1'b0,
    delimiter_count:   4'd1,
    delimiter_pattern: 64'd10,
    max_record_bytes:  32'd67108864
  };

endpackage
`default_nettype wire

### hdl/rds_front.sv
// Input stage: takes stream items and classifies each byte against the delimiters.
`default_nettype none
module rds_front #(
  parameter int MAX_DELIMITER_BYTES = rds_pkg::DEFAULT_MAX_DELIMITER_BYTES,
  parameter int ITEM_W = rds_pkg::ITEM_MATCH_LSB + MAX_DELIMITER_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           byte_valid,
  output logic                                byte_stall,
  input  wire logic                           action,
  input  wire logic [7:0]                     data_byte,
  input  wire logic [rds_pkg::PATTERN_W-1:0]  delimiter_pattern,
  input  wire logic                           queue_full,
  output logic                                push,
  output logic [ITEM_W-1:0]                   item
);

  logic              item_valid;
  logic [ITEM_W-1:0] item_next;

  always_comb begin
    item_next = '0;
    item_next[rds_pkg::ITEM_ACTION_BIT] = action;
    item_next[rds_pkg::ITEM_LF_BIT] = (data_byte == rds_pkg::BYTE_LF);
    item_next[rds_pkg::ITEM_CR_BIT] = (data_byte == rds_pkg::BYTE_CR);
    for (int i = 0; i < MAX_DELIMITER_BYTES; i++) begin
      item_next[rds_pkg::ITEM_MATCH_LSB + i] = (data_byte == delimiter_pattern[8*i +: 8]);
    end
  end

  assign byte_stall = item_valid && queue_full;
  assign push = item_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!byte_stall) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

### hdl/rds_queue.sv
// Short queue of classified items between the input stage and the record stage.
`default_nettype none
module rds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rds_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`include "record_delimiter_splitter_assert.svh"

  `RDS_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `RDS_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full || pop)
  `RDS_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, not_empty)

endmodule
`default_nettype wire

### hdl/rds_back.sv
// Record stage: tracks line and delimiter matching and registers each record end.
`default_nettype none
module rds_back #(
  parameter int MAX_DELIMITER_BYTES = rds_pkg::DEFAULT_MAX_DELIMITER_BYTES,
  parameter int ITEM_W = rds_pkg::ITEM_MATCH_LSB + MAX_DELIMITER_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rds_pkg::cfg_t                cfg,
  input  wire logic                         item_valid,
  input  wire logic [ITEM_W-1:0]            item,
  output logic                              pop,
  output logic                              record_valid,
  input  wire logic                         record_stall,
  output logic [rds_pkg::LEN_W-1:0]         record_length,
  output logic [rds_pkg::TERM_W-1:0]        terminator_length,
  output logic [rds_pkg::POS_W-1:0]         end_offset,
  output logic                              status
);

  localparam int IDX_W = (MAX_DELIMITER_BYTES > 1) ? $clog2(MAX_DELIMITER_BYTES) : 1;
  localparam int LEN_W = rds_pkg::LEN_W;
  localparam int TERM_W = rds_pkg::TERM_W;
  localparam int POS_W = rds_pkg::POS_W;

  logic                 cr_pending;
  logic                 cr_pending_next;
  logic [IDX_W-1:0]     progress;
  logic [IDX_W-1:0]     progress_next;
  logic [LEN_W-1:0]     length;
  logic [LEN_W-1:0]     length_next;
  logic [POS_W-1:0]     position;
  logic [POS_W-1:0]     position_next;
  logic                 overlong;
  logic                 overlong_next;

  logic                 is_flush;
  logic                 is_lf;
  logic                 is_cr;
  logic [MAX_DELIMITER_BYTES-1:0] match;
  logic                 line_mode;
  logic                 restart;
  logic [LEN_W-1:0]     base_length;
  logic                 base_overlong;
  logic [LEN_W-1:0]     grown_length;
  logic                 grown_overlong;
  logic [POS_W-1:0]     position_inc;
  logic [TERM_W-1:0]    count;
  logic [TERM_W-1:0]    progress_cand;
  logic                 slot_free;

  logic                 emit;
  logic [LEN_W-1:0]     emit_length;
  logic [TERM_W-1:0]    emit_term;
  logic [POS_W-1:0]     emit_offset;
  logic                 emit_overlong;

  assign is_flush = (item[rds_pkg::ITEM_ACTION_BIT] == rds_pkg::ACTION_FLUSH);
  assign is_lf = item[rds_pkg::ITEM_LF_BIT];
  assign is_cr = item[rds_pkg::ITEM_CR_BIT];
  assign match = item[rds_pkg::ITEM_MATCH_LSB +: MAX_DELIMITER_BYTES];
  assign line_mode = (cfg.delimiter_mode == rds_pkg::MODE_LINE);

  assign slot_free = !record_valid || !record_stall;
  assign pop = item_valid && slot_free;

  // A lone CR closes the open record before the current byte starts the next one.
  assign restart = line_mode && cr_pending && !is_lf;
  assign base_length = restart ? '0 : length;
  assign base_overlong = restart ? 1'b0 : overlong;
  assign grown_length = (base_length == '1) ? base_length : base_length + 1'b1;
  assign grown_overlong = base_overlong || (grown_length > cfg.max_record_bytes);
  assign position_inc = position + 1'b1;

  always_comb begin
    if (cfg.delimiter_count == '0) begin
      count = TERM_W'(1);
    end else if (cfg.delimiter_count > TERM_W'(MAX_DELIMITER_BYTES)) begin
      count = TERM_W'(MAX_DELIMITER_BYTES);
    end else begin
      count = cfg.delimiter_count;
    end
  end

  assign progress_cand = match[progress] ? TERM_W'(progress) + 1'b1 : TERM_W'(match[0]);

  always_comb begin
    cr_pending_next = cr_pending;
    progress_next = progress;
    length_next = length;
    position_next = position;
    overlong_next = overlong;
    emit = 1'b0;
    emit_length = length;
    emit_term = '0;
    emit_offset = position;
    emit_overlong = overlong;
    if (pop) begin
      if (is_flush) begin
        emit = (length != '0);
        emit_term = (line_mode && cr_pending) ? TERM_W'(1) : TERM_W'(0);
        cr_pending_next = 1'b0;
        progress_next = '0;
        length_next = '0;
        position_next = '0;
        overlong_next = 1'b0;
      end else begin
        position_next = position_inc;
        length_next = grown_length;
        overlong_next = grown_overlong;
        if (line_mode) begin
          if (is_lf) begin
            emit = 1'b1;
            emit_length = grown_length;
            emit_overlong = grown_overlong;
            emit_term = cr_pending ? TERM_W'(2) : TERM_W'(1);
            emit_offset = position_inc;
            cr_pending_next = 1'b0;
            progress_next = '0;
            length_next = '0;
            overlong_next = 1'b0;
          end else begin
            if (cr_pending) begin
              emit = 1'b1;
              emit_term = TERM_W'(1);
              progress_next = '0;
            end
            cr_pending_next = is_cr;
          end
        end else begin
          if (progress_cand >= count) begin
            emit = 1'b1;
            emit_length = grown_length;
            emit_overlong = grown_overlong;
            emit_term = count;
            emit_offset = position_inc;
            cr_pending_next = 1'b0;
            progress_next = '0;
            length_next = '0;
            overlong_next = 1'b0;
          end else begin
            progress_next = IDX_W'(progress_cand);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending <= 1'b0;
      progress <= '0;
      length <= '0;
      position <= '0;
      overlong <= 1'b0;
      record_valid <= 1'b0;
    end else begin
      cr_pending <= cr_pending_next;
      progress <= progress_next;
      length <= length_next;
      position <= position_next;
      overlong <= overlong_next;
      if (emit) begin
        record_valid <= 1'b1;
      end else if (!record_stall) begin
        record_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      record_length <= emit_length;
      terminator_length <= emit_term;
      end_offset <= emit_offset;
      status <= emit_overlong;
    end
  end

`include "record_delimiter_splitter_assert.svh"

  `RDS_ASSERT_ALWAYS(a_progress_range, clk, rst,
                     progress <= IDX_W'(MAX_DELIMITER_BYTES - 1))
  `RDS_ASSERT_IMPLIES(a_record_nonempty, clk, rst, record_valid, record_length != '0)
  `RDS_ASSERT_IMPLIES(a_cr_in_record, clk, rst, cr_pending, length != '0)
  `RDS_ASSERT_NEXT(a_flush_rewinds, clk, rst, pop && is_flush, position == '0 && length == '0)

endmodule
`default_nettype wire

### hdl/record_delimiter_splitter.sv
// Top level of the record delimiter splitter: configuration registers and stage wiring.
//
//   channel  direction  handshake               payload
//   byte     in         byte_valid/byte_stall   action, data_byte
//   record   out        record_valid/record_stall
//                                               record_length, terminator_length,
//                                               end_offset, status
//   cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One stream item is taken per cycle while byte_stall is low; the record stage updates its state
// for each popped item. A record end passes the input stage register, the queue and the record
// stage output registers before it is offered, and waits further while the output stalls.
// Synchronous reset empties every stage and restores the register defaults; it needs no sweep.
// A stalled record output holds the queue; the input stalls only once the queue and input
// stage are full. Configuration writes are always taken.
`default_nettype none
module record_delimiter_splitter #(
  parameter int MAX_DELIMITER_BYTES = rds_pkg::DEFAULT_MAX_DELIMITER_BYTES,
  parameter int QUEUE_DEPTH = rds_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            byte_valid,
  output logic                                 byte_stall,
  input  wire logic                            action,
  input  wire logic [7:0]                      data_byte,
  output logic                                 record_valid,
  input  wire logic                            record_stall,
  output logic [rds_pkg::LEN_W-1:0]            record_length,
  output logic [rds_pkg::TERM_W-1:0]           terminator_length,
  output logic [rds_pkg::POS_W-1:0]            end_offset,
  output logic                                 status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ITEM_W = rds_pkg::ITEM_MATCH_LSB + MAX_DELIMITER_BYTES;

  rds_pkg::cfg_t     cfg;
  logic              push;
  logic [ITEM_W-1:0] push_item;
  logic              queue_full;
  logic              pop;
  logic              queue_valid;
  logic [ITEM_W-1:0] pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= rds_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rds_pkg::REG_DELIMITER_MODE: begin
          cfg.delimiter_mode <= cfg_data[0];
        end
        rds_pkg::REG_DELIMITER_COUNT: begin
          cfg.delimiter_count <= cfg_data[rds_pkg::TERM_W-1:0];
        end
        rds_pkg::REG_DELIMITER_PATTERN: begin
          cfg.delimiter_pattern <= cfg_data[rds_pkg::PATTERN_W-1:0];
        end
        rds_pkg::REG_MAX_RECORD_BYTES: begin
          cfg.max_record_bytes <= cfg_data[rds_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  rds_front #(
    .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES),
    .ITEM_W              (ITEM_W)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .byte_stall        (byte_stall),
    .action            (action),
    .data_byte         (data_byte),
    .delimiter_pattern (cfg.delimiter_pattern),
    .queue_full        (queue_full),
    .push              (push),
    .item              (push_item)
  );

  rds_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .pop_data  (pop_item)
  );

  rds_back #(
    .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES),
    .ITEM_W              (ITEM_W)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .item_valid        (queue_valid),
    .item              (pop_item),
    .pop               (pop),
    .record_valid      (record_valid),
    .record_stall      (record_stall),
    .record_length     (record_length),
    .terminator_length (terminator_length),
    .end_offset        (end_offset),
    .status            (status)
  );

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the record delimiter splitter: directed and random byte streams.
`timescale 1ns / 1ps
module tb;

  localparam logic ACTION_DATA = 1'b0;
  localparam logic MODE_CUSTOM = 1'b1;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    logic [rds_pkg::LEN_W-1:0]  length;
    logic [rds_pkg::TERM_W-1:0] term;
    logic [rds_pkg::POS_W-1:0]  offset;
    logic                       status;
  } record_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            byte_valid = 1'b0;
  logic                            byte_stall;
  logic                            action = ACTION_DATA;
  logic [7:0]                      data_byte = 8'd0;
  logic                            record_valid;
  logic                            record_stall = 1'b0;
  logic [rds_pkg::LEN_W-1:0]       record_length;
  logic [rds_pkg::TERM_W-1:0]      terminator_length;
  logic [rds_pkg::POS_W-1:0]       end_offset;
  logic                            status;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rds_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rds_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the splitter's registers and record state.
  rds_pkg::cfg_t             cfg_model = rds_pkg::CFG_RESET;
  logic                      cr_seen = 1'b0;
  logic [3:0]                matched = '0;
  logic [rds_pkg::LEN_W-1:0] record_bytes = '0;
  logic [rds_pkg::POS_W-1:0] stream_offset = '0;
  logic                      too_long = 1'b0;

  record_t expected_records[$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  int      burst_max = 4;
  int      gap_max = 2;
  int      stall_pct = 20;
  int      stall_run = 0;
  logic    stall_now;

  record_delimiter_splitter i_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .action(action),
    .data_byte(data_byte),
    .record_valid(record_valid),
    .record_stall(record_stall),
    .record_length(record_length),
    .terminator_length(terminator_length),
    .end_offset(end_offset),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pattern_byte(input logic [3:0] idx);
    return cfg_model.delimiter_pattern[idx[2:0]*8 +: 8];
  endfunction

  function automatic int unsigned delimiter_span();
    if (cfg_model.delimiter_count == 0) return 1;
    if (cfg_model.delimiter_count > rds_pkg::DEFAULT_MAX_DELIMITER_BYTES)
      return rds_pkg::DEFAULT_MAX_DELIMITER_BYTES;
    return cfg_model.delimiter_count;
  endfunction

  function automatic void count_byte();
    if (record_bytes != '1) record_bytes = record_bytes + 1'b1;
    if (record_bytes > cfg_model.max_record_bytes) too_long = 1'b1;
  endfunction

  function automatic void close_record(input logic [rds_pkg::TERM_W-1:0] term,
                                       input logic [rds_pkg::POS_W-1:0] offset);
    record_t rec;
    rec.length = record_bytes;
    rec.term = term;
    rec.offset = offset;
    rec.status = too_long;
    expected_records.push_back(rec);
    record_bytes = '0;
    too_long = 1'b0;
    cr_seen = 1'b0;
    matched = '0;
  endfunction

  function automatic void predict_records(input logic act, input logic [7:0] value);
    logic [rds_pkg::POS_W-1:0] prior;
    int unsigned               span;
    prior = stream_offset;
    if (act == rds_pkg::ACTION_FLUSH) begin
      if (record_bytes != 0)
        close_record((cfg_model.delimiter_mode == rds_pkg::MODE_LINE && cr_seen) ?
                     4'd1 : 4'd0, prior);
      cr_seen = 1'b0;
      matched = '0;
      record_bytes = '0;
      too_long = 1'b0;
      stream_offset = '0;
      return;
    end
    stream_offset = stream_offset + 1'b1;
    if (cfg_model.delimiter_mode == rds_pkg::MODE_LINE) begin
      if (value == rds_pkg::BYTE_LF) begin
        count_byte();
        close_record(cr_seen ? 4'd2 : 4'd1, stream_offset);
        return;
      end
      if (cr_seen) close_record(4'd1, prior);
      count_byte();
      cr_seen = (value == rds_pkg::BYTE_CR);
      return;
    end
    span = delimiter_span();
    count_byte();
    if (value == pattern_byte(matched)) begin
      matched = matched + 1'b1;
      if (matched >= span) begin
        close_record(span[rds_pkg::TERM_W-1:0], stream_offset);
        return;
      end
    end else if (matched != 0) begin
      matched = (value == pattern_byte(4'd0)) ? 4'd1 : 4'd0;
      if (matched >= span) begin
        close_record(span[rds_pkg::TERM_W-1:0], stream_offset);
        return;
      end
    end
    if (matched >= rds_pkg::DEFAULT_MAX_DELIMITER_BYTES) matched = '0;
  endfunction

  // Receiver stall pattern: runs of stall or ready of random length, each picked at random.
  always @(posedge clk) begin
    if (rst) begin
      record_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run == 0) begin
      stall_now = ($urandom_range(0, 99) < stall_pct);
      stall_run = stall_now ? $urandom_range(1, 8) : $urandom_range(1, 20);
      record_stall <= stall_now;
    end else begin
      stall_run = stall_run - 1;
    end
  end

  // Every record transfer is matched against the oldest expected record.
  always @(posedge clk) begin
    if (!rst && record_valid && !record_stall) begin
      if (expected_records.size() == 0) begin
        $error("Record transfer with no record expected: length %0d", record_length);
        error_count++;
      end else begin
        record_t rec;
        rec = expected_records.pop_front();
        if (record_length !== rec.length) begin
          $error("record_length: expected %0d, actual %0d", rec.length, record_length);
          error_count++;
        end
        if (terminator_length !== rec.term) begin
          $error("terminator_length: expected %0d, actual %0d", rec.term, terminator_length);
          error_count++;
        end
        if (end_offset !== rec.offset) begin
          $error("end_offset: expected %0d, actual %0d", rec.offset, end_offset);
          error_count++;
        end
        if (status !== rec.status) begin
          $error("status: expected %0d, actual %0d", rec.status, status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (record_valid && !record_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic act, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
          byte_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, burst_max);
    end
    byte_valid <= 1'b1;
    action <= act;
    data_byte <= value;
    do @(posedge clk); while (byte_stall);
    predict_records(act, value);
    burst_left--;
    items_sent++;
  endtask

  task automatic settle();
    byte_valid <= 1'b0;
    burst_left = 0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic mode, input logic [3:0] count,
                           input logic [rds_pkg::PATTERN_W-1:0] pattern,
                           input logic [rds_pkg::LEN_W-1:0] limit);
    logic [rds_pkg::CFG_DATA_W-1:0]  values [4];
    logic [rds_pkg::CFG_INDEX_W-1:0] reg_index;
    settle();
    values[rds_pkg::REG_DELIMITER_MODE] = rds_pkg::CFG_DATA_W'(mode);
    values[rds_pkg::REG_DELIMITER_COUNT] = rds_pkg::CFG_DATA_W'(count);
    values[rds_pkg::REG_DELIMITER_PATTERN] = pattern;
    values[rds_pkg::REG_MAX_RECORD_BYTES] = rds_pkg::CFG_DATA_W'(limit);
    for (int i = 0; i < 4; i++) begin
      reg_index = i[rds_pkg::CFG_INDEX_W-1:0];
      cfg_valid <= 1'b1;
      cfg_index <= reg_index;
      cfg_data <= values[reg_index];
      do @(posedge clk); while (!cfg_ready);
      case (reg_index)
        rds_pkg::REG_DELIMITER_MODE:
          cfg_model.delimiter_mode = values[reg_index][0];
        rds_pkg::REG_DELIMITER_COUNT:
          cfg_model.delimiter_count = values[reg_index][rds_pkg::TERM_W-1:0];
        rds_pkg::REG_DELIMITER_PATTERN:
          cfg_model.delimiter_pattern = values[reg_index];
        default:
          cfg_model.max_record_bytes = values[reg_index][rds_pkg::LEN_W-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Line mode at the reset settings: LF, CR LF, a lone CR, and flushes.
  task automatic test_line_endings();
    send_byte(ACTION_DATA, 8'h00);
    send_byte(ACTION_DATA, rds_pkg::BYTE_LF);
    send_byte(ACTION_DATA, rds_pkg::BYTE_CR);
    send_byte(ACTION_DATA, rds_pkg::BYTE_LF);
    send_byte(ACTION_DATA, 8'hFF);
    send_byte(ACTION_DATA, rds_pkg::BYTE_CR);
    send_byte(ACTION_DATA, 8'h41);
    send_byte(ACTION_DATA, rds_pkg::BYTE_CR);
    send_byte(rds_pkg::ACTION_FLUSH, 8'h00);
    send_byte(rds_pkg::ACTION_FLUSH, 8'hFF);
  endtask

  task automatic test_custom_delimiter();
    // A false start on the first delimiter byte must restart the match.
    configure(MODE_CUSTOM, 4'd3, 64'h434241, 32'd67108864);
    send_byte(ACTION_DATA, 8'h41);
    send_byte(ACTION_DATA, 8'h41);
    send_byte(ACTION_DATA, 8'h42);
    send_byte(ACTION_DATA, 8'h43);
    // A count of zero acts as one, and a zero maximum marks every record overlong.
    configure(MODE_CUSTOM, 4'd0, 64'h41, 32'd0);
    send_byte(ACTION_DATA, 8'h41);
    // A count above the maximum acts as the maximum.
    configure(MODE_CUSTOM, 4'd15, 64'hFF00_5A0D_0A7E_8001, 32'hFFFF_FFFF);
    for (int i = 0; i < rds_pkg::DEFAULT_MAX_DELIMITER_BYTES; i++)
      send_byte(ACTION_DATA, pattern_byte(i[3:0]));
    // Shrinking the count after a partial match completes on the next matching byte.
    configure(MODE_CUSTOM, 4'd4, 64'h44434241, 32'd2);
    send_byte(ACTION_DATA, 8'h41);
    send_byte(ACTION_DATA, 8'h42);
    send_byte(ACTION_DATA, 8'h43);
    configure(MODE_CUSTOM, 4'd2, 64'h44434241, 32'd2);
    send_byte(ACTION_DATA, 8'h44);
  endtask

  // A pending CR survives a spell in custom mode and ends the record on return.
  task automatic test_mode_switch();
    configure(rds_pkg::MODE_LINE, 4'd2, 64'h44434241, 32'd2);
    send_byte(ACTION_DATA, 8'h78);
    send_byte(ACTION_DATA, rds_pkg::BYTE_CR);
    configure(MODE_CUSTOM, 4'd2, 64'h44434241, 32'd2);
    send_byte(ACTION_DATA, 8'h79);
    configure(rds_pkg::MODE_LINE, 4'd2, 64'h44434241, 32'd2);
    send_byte(ACTION_DATA, 8'h7A);
    send_byte(rds_pkg::ACTION_FLUSH, 8'h00);
  endtask

  task automatic send_delimiter();
    int unsigned span;
    span = delimiter_span();
    for (int unsigned i = 0; i < span; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(ACTION_DATA, 8'($urandom));
        break;
      end
      send_byte(ACTION_DATA, pattern_byte(i[3:0]));
    end
  endtask

  task automatic test_random_stream();
    logic                          mode;
    logic [3:0]                    count;
    logic [rds_pkg::PATTERN_W-1:0] pattern;
    logic [rds_pkg::LEN_W-1:0]     limit;
    logic [7:0]                    pair [2];
    int                            target;
    int                            pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = p[0] ? MODE_CUSTOM : rds_pkg::MODE_LINE;
      case (p)
        1:       count = 4'd1;
        3:       count = 4'd8;
        5:       count = 4'd0;
        7:       count = 4'd15;
        default: count = 4'($urandom_range(1, 8));
      endcase
      case (p % 5)
        0:       limit = 32'($urandom_range(1, 40));
        1:       limit = 32'hFFFF_FFFF;
        2:       limit = 32'd0;
        3:       limit = 32'd1;
        default: limit = $urandom;
      endcase
      pair[0] = 8'($urandom);
      pair[1] = 8'($urandom);
      case ($urandom_range(0, 3))
        0:       pattern = {$urandom, $urandom};
        1:       pattern = {8{pair[0]}};
        2:       for (int b = 0; b < 8; b++) pattern[b*8 +: 8] = pair[1'($urandom_range(0, 1))];
        default: pattern = {$urandom, 24'($urandom), rds_pkg::BYTE_CR};
      endcase
      configure(mode, count, pattern, limit);
      case (p % 3)
        0: begin gap_max = 0; burst_max = 1; stall_pct = 0; end
        1: begin gap_max = 3; burst_max = 20; stall_pct = 25; end
        default: begin gap_max = 10; burst_max = 6; stall_pct = 60; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_byte(rds_pkg::ACTION_FLUSH, 8'($urandom));
        end else if (mode == rds_pkg::MODE_LINE) begin
          if (pick < 23) begin
            send_byte(ACTION_DATA, rds_pkg::BYTE_LF);
          end else if (pick < 43) begin
            send_byte(ACTION_DATA, rds_pkg::BYTE_CR);
          end else if (pick < 50) begin
            send_byte(ACTION_DATA, rds_pkg::BYTE_CR);
            send_byte(ACTION_DATA, rds_pkg::BYTE_LF);
          end else begin
            send_byte(ACTION_DATA, 8'($urandom));
          end
        end else if (pick < 45) begin
          send_delimiter();
        end else if (pick < 75) begin
          send_byte(ACTION_DATA, pattern_byte(4'($urandom_range(0, 7))));
        end else begin
          send_byte(ACTION_DATA, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_line_endings();
    test_custom_delimiter();
    test_mode_switch();
    test_random_stream();
    settle();
    if (error_count == 0 && expected_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
